// ===== hw/rtl/lcd_mode_timing_controller_unit_defines.svh =====
// ----------------------------------------------------------------------------
// LCD mode timing controller: assertion macros
// Shared property macros for the checker of the timing controller.
// ----------------------------------------------------------------------------
`ifndef LCD_MODE_TIMING_CONTROLLER_UNIT_DEFINES_SVH
`define LCD_MODE_TIMING_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LMTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LMTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lmtc_pkg.sv =====
// ----------------------------------------------------------------------------
// LMTC package
// Types and timing constants of the LCD mode timing controller.
// ----------------------------------------------------------------------------
package lmtc_pkg;

  localparam int LINE_CYCLES = 456;  // cycles per scan line
  localparam int FRAME_LINES = 154;  // lines per frame
  localparam int VBLANK_LINE = 144;  // first vblank line (cycle 65664)
  localparam int MODE2_END   = 80;   // last line cycle of object scan
  localparam int MODE3_END   = 252;  // last line cycle of transfer

  localparam logic [1:0] MODE_HBLANK   = 2'd0;
  localparam logic [1:0] MODE_VBLANK   = 2'd1;
  localparam logic [1:0] MODE_SCAN     = 2'd2;
  localparam logic [1:0] MODE_TRANSFER = 2'd3;

  typedef struct packed {
    logic [7:0] cycles;
    logic       lcd_enable;
    logic [7:0] line_compare;
    logic       hblank_irq_enable;
    logic       vblank_stat_enable;
    logic       oam_irq_enable;
    logic       match_irq_enable;
  } step_item_t;

  typedef struct packed {
    logic [7:0] line_number;
    logic [1:0] lcd_mode;
    logic       coincidence;
    logic       vblank_request;
    logic       stat_request;
    logic       render_line;
    logic       present_frame;
  } report_item_t;

  // Frame position is kept as line and position within the line, so no
  // division is needed; line_cycle is the separate mode counter.
  typedef struct packed {
    logic [7:0] line;
    logic [8:0] line_pos;
    logic [8:0] line_cycle;
    logic [1:0] mode;
    logic       match;
  } timing_state_t;

endpackage

// ===== hw/rtl/lmtc_step_if.sv =====
// ----------------------------------------------------------------------------
// LMTC step channel
// Valid/ready channel carrying one elapsed-cycle item.
// ----------------------------------------------------------------------------
interface lmtc_step_if;
  import lmtc_pkg::*;

  logic       valid;
  logic       ready;
  step_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lmtc_report_if.sv =====
// ----------------------------------------------------------------------------
// LMTC report channel
// Valid/ready channel carrying one timing status item.
// ----------------------------------------------------------------------------
interface lmtc_report_if;
  import lmtc_pkg::*;

  logic         valid;
  logic         ready;
  report_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lmtc_step.sv =====
// ----------------------------------------------------------------------------
// LMTC step logic
// Next timing state and status item for one elapsed-cycle item.
// ----------------------------------------------------------------------------
module lmtc_step (
  input  lmtc_pkg::timing_state_t cur,
  input  lmtc_pkg::step_item_t    item,
  output lmtc_pkg::timing_state_t nxt,
  output lmtc_pkg::report_item_t  res
);
  import lmtc_pkg::*;

  logic [9:0] pos_sum;
  logic [8:0] pos_next;
  logic       carry;
  logic [7:0] line_inc;
  logic       wrap;
  logic [7:0] line_next;
  logic       vblank;
  logic [8:0] lc_base;
  logic [9:0] lc_sum;
  logic [8:0] lc_next;

  // Advance frame position; a step never spans more than one line boundary.
  always_comb begin
    pos_sum   = {1'b0, cur.line_pos} + {2'b00, item.cycles};
    carry     = pos_sum >= 10'(LINE_CYCLES);
    pos_next  = carry ? 9'(pos_sum - 10'(LINE_CYCLES)) : pos_sum[8:0];
    line_inc  = cur.line + {7'd0, carry};
    wrap      = line_inc == 8'(FRAME_LINES);
    line_next = wrap ? 8'd0 : line_inc;
    vblank    = line_next >= 8'(VBLANK_LINE);
    // On frame wrap the mode counter restarts at the leftover frame count.
    lc_base   = wrap ? pos_next : cur.line_cycle;
    lc_sum    = {1'b0, lc_base} + {2'b00, item.cycles};
    lc_next   = (lc_sum >= 10'(LINE_CYCLES)) ? 9'(lc_sum - 10'(LINE_CYCLES))
                                             : lc_sum[8:0];
  end

  always_comb begin
    nxt          = cur;
    nxt.line     = line_next;
    nxt.line_pos = pos_next;
    res          = '0;
    res.line_number = line_next;

    // Line compare, only while the LCD is on; flag holds otherwise.
    if (item.lcd_enable) begin
      if (line_next == item.line_compare) begin
        if (!cur.match) begin
          nxt.match        = 1'b1;
          res.stat_request = item.match_irq_enable;
        end
      end else begin
        nxt.match = 1'b0;
      end
    end

    if (vblank) begin
      // Mode counter holds through vblank.
      if (cur.mode != MODE_VBLANK) begin
        nxt.mode           = MODE_VBLANK;
        res.present_frame  = 1'b1;
        res.vblank_request = 1'b1;
        if (item.vblank_stat_enable) begin
          res.stat_request = 1'b1;
        end
      end
    end else begin
      nxt.line_cycle = lc_next;
      if (lc_next <= 9'(MODE2_END)) begin
        if (cur.mode != MODE_SCAN) begin
          nxt.mode = MODE_SCAN;
          if (item.oam_irq_enable) begin
            res.stat_request = 1'b1;
          end
        end
      end else if (lc_next <= 9'(MODE3_END)) begin
        nxt.mode = MODE_TRANSFER;
      end else if (cur.mode != MODE_HBLANK) begin
        nxt.mode        = MODE_HBLANK;
        res.render_line = 1'b1;
        if (item.hblank_irq_enable) begin
          res.stat_request = 1'b1;
        end
      end
    end

    res.lcd_mode    = nxt.mode;
    res.coincidence = nxt.match;
  end
endmodule

// ===== hw/rtl/lcd_mode_timing_controller_unit.sv =====
// ----------------------------------------------------------------------------
// LCD mode timing controller
// Scan line and LCD mode sequencer with STAT and vblank request generation.
// ----------------------------------------------------------------------------
// Usage:
//   step   : one item per handshake with the cycles elapsed since the last
//            item plus LCD enable, line compare value and STAT enable bits.
//   report : one item per step item: line number, LCD mode, coincidence
//            flag, vblank/STAT requests and render/present strobes.
//   A step item accepted on step passes two register stages (input
//   register, result register) before it shows on report.
//   Throughput: one item per cycle while report.ready is high; the state
//   update is a few 10-bit adds and constant compares between the registers.
//   Reset (rst, synchronous): the frame starts at line 0, cycle 0, mode 0,
//   coincidence clear; both stages empty.
//   Stall: when report.ready is low the result register holds its item, the
//   input register fills, and step.ready drops only once both are full.
//   No item is dropped or repeated.
// ----------------------------------------------------------------------------
module lcd_mode_timing_controller_unit (
  input  logic            clk,
  input  logic            rst,
  lmtc_step_if.sink       step,
  lmtc_report_if.source   report
);
  import lmtc_pkg::*;

  logic          in_valid;
  step_item_t    in_data;
  logic          out_valid;
  report_item_t  out_data;
  timing_state_t state;
  timing_state_t state_next;
  report_item_t  res;
  logic          advance;

  // Move the held item into the result register when that one is free.
  assign advance    = in_valid && (!out_valid || report.ready);
  assign step.ready = !in_valid || advance;

  lmtc_step u_step (
    .cur  (state),
    .item (in_data),
    .nxt  (state_next),
    .res  (res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (step.valid && step.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.valid && step.ready) begin
      in_data <= step.data;
    end
  end

  // Timing state: commit only when the item leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

  assign report.valid = out_valid;
  assign report.data  = out_data;
endmodule

// ===== hw/rtl/lmtc_checker.sv =====
// ----------------------------------------------------------------------------
// LMTC checker
// Port-level properties of the LCD mode timing controller.
// ----------------------------------------------------------------------------
`include "lcd_mode_timing_controller_unit_defines.svh"

module lmtc_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  report_valid,
  input logic                  report_ready,
  input lmtc_pkg::report_item_t report_data
);
  import lmtc_pkg::*;

  // A stalled result holds.
  `LMTC_ASSERT_NEXT(a_stall_hold, report_valid && !report_ready, report_valid && $stable(report_data), "report item changed while stalled")

  // Vblank mode exactly on the vblank lines, and lines stay in the frame.
  `LMTC_ASSERT_NOW(a_vblank_lines, report_valid, (report_data.line_number < 8'(FRAME_LINES)) && ((report_data.line_number >= 8'(VBLANK_LINE)) == (report_data.lcd_mode == MODE_VBLANK)), "mode does not agree with line number")

  // Render strobe only on hblank entry.
  `LMTC_ASSERT_NOW(a_render_mode, report_valid && report_data.render_line, report_data.lcd_mode == MODE_HBLANK && !report_data.present_frame, "render strobe outside hblank")

  // Present strobe and vblank request come together, in vblank.
  `LMTC_ASSERT_NOW(a_present_vblank, report_valid, (report_data.present_frame == report_data.vblank_request) && (!report_data.present_frame || report_data.lcd_mode == MODE_VBLANK), "present strobe and vblank request disagree")
endmodule

bind lcd_mode_timing_controller_unit lmtc_checker u_lmtc_checker (
  .clk          (clk),
  .rst          (rst),
  .report_valid (report.valid),
  .report_ready (report.ready),
  .report_data  (report.data)
);

// ===== bench/tb_lcd_mode_timing_controller_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD mode timing controller testbench
// Drives elapsed-cycle items into step and checks each report item against
// its typed table row or a cycle-exact model of the frame, line and mode
// counters, coincidence flag and request strobes. A short table of directed
// items runs first, then random items shaped to reach vblank and frame wrap.
// ----------------------------------------------------------------------------
module tb_lcd_mode_timing_controller_unit;
  import lmtc_pkg::*;

  localparam int FRAME_TOTAL   = LINE_CYCLES * FRAME_LINES;  // 70224
  localparam int VBLANK_START  = LINE_CYCLES * VBLANK_LINE;  // 65664
  localparam int RANDOM_ITEMS  = 1000;
  localparam int STALL_LIMIT   = 4000;  // cycles with no handshake before giving up
  localparam int DRAIN_CYCLES  = 16;    // two pipeline stages, with margin
  localparam int PROBE_COUNT   = 20;

  logic clk;
  logic rst;

  lmtc_step_if   step ();
  lmtc_report_if report ();

  lcd_mode_timing_controller_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .report (report)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Timing model: frame position, separate line-cycle counter, current mode
  // and the coincidence flag; the block keeps the frame position as line and line_pos.
  // --------------------------------------------------------------------------
  logic [16:0] frame_pos;
  logic [8:0]  mode_pos;
  logic [1:0]  cur_mode;
  logic        line_match;

  report_item_t expected_reports [$];
  int           error_count;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           quiet_cycles = 0;
  int           items_sent;

  report_item_t got_report;
  report_item_t want_report;

  // Directed items. Rows marked typed carry the result read straight off the
  // timing rules; the rest are checked against the model.
  typedef struct packed {
    step_item_t   stim;
    logic         typed;
    report_item_t want;
  } probe_row_t;

  // stim: cycles, lcd_enable, line_compare, {hblank, vblank, oam, match} enables
  // want: line, mode, {coincidence, vblank_req, stat_req, render, present}
  probe_row_t probe_table [PROBE_COUNT] = '{
    // first step after reset: line 0 matches and object scan is entered
    {8'd0,   1'b1, 8'd0,   4'b1111, 1'b1, 8'd0, MODE_SCAN,     5'b10100},
    // last cycle of object scan, flag already set so no second match request
    {8'd80,  1'b1, 8'd0,   4'b1111, 1'b1, 8'd0, MODE_SCAN,     5'b10000},
    // transfer entry raises nothing
    {8'd1,   1'b1, 8'd0,   4'b1111, 1'b1, 8'd0, MODE_TRANSFER, 5'b10000},
    // LCD off holds the flag even though the compare value differs
    {8'd171, 1'b0, 8'd255, 4'b1111, 1'b1, 8'd0, MODE_TRANSFER, 5'b10000},
    // hblank entry: render strobe and STAT; mismatch clears the flag
    {8'd1,   1'b1, 8'd255, 4'b1111, 1'b1, 8'd0, MODE_HBLANK,   5'b00110},
    // last cycle of the line, no entry
    {8'd202, 1'b1, 8'd1,   4'b1111, 1'b1, 8'd0, MODE_HBLANK,   5'b00000},
    // line 1: scan entry and match with both their requests disabled
    {8'd1,   1'b1, 8'd1,   4'b1100, 1'b1, 8'd1, MODE_SCAN,     5'b10000},
    // largest step skips transfer entirely; hblank request disabled
    {8'd255, 1'b0, 8'd1,   4'b0111, 1'b1, 8'd1, MODE_HBLANK,   5'b10010},
    {8'd255, 1'b1, 8'd2,   4'b1111, 1'b0, 8'd0, MODE_HBLANK,   5'b00000},
    {8'd0,   1'b1, 8'd2,   4'b0000, 1'b0, 8'd0, MODE_HBLANK,   5'b00000},
    {8'd128, 1'b0, 8'd153, 4'b1010, 1'b0, 8'd0, MODE_HBLANK,   5'b00000},
    {8'd255, 1'b1, 8'd255, 4'b0101, 1'b0, 8'd0, MODE_HBLANK,   5'b00000},
    {8'd255, 1'b1, 8'd3,   4'b1111, 1'b0, 8'd0, MODE_HBLANK,   5'b00000},
    {8'd3,   1'b1, 8'd3,   4'b1111, 1'b0, 8'd0, MODE_HBLANK,   5'b00000},
    {8'd200, 1'b1, 8'd4,   4'b0011, 1'b0, 8'd0, MODE_HBLANK,   5'b00000},
    {8'd255, 1'b0, 8'd0,   4'b1100, 1'b0, 8'd0, MODE_HBLANK,   5'b00000},
    {8'd255, 1'b1, 8'd5,   4'b1111, 1'b0, 8'd0, MODE_HBLANK,   5'b00000},
    {8'd64,  1'b1, 8'd128, 4'b0000, 1'b0, 8'd0, MODE_HBLANK,   5'b00000},
    {8'd255, 1'b1, 8'd6,   4'b1111, 1'b0, 8'd0, MODE_HBLANK,   5'b00000},
    {8'd127, 1'b1, 8'd7,   4'b1000, 1'b0, 8'd0, MODE_HBLANK,   5'b00000}
  };

  task automatic flag_error(input string msg);
    $display("%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      flag_error($sformatf("%s mismatch: got %0d, want %0d", name, got, want));
  endtask

  // Advance the timing model by one item and return the report it causes.
  task automatic advance_timing(input step_item_t it, output report_item_t r);
    int fpos;
    int mpos;
    int scan_line;
    r    = '0;
    fpos = int'(frame_pos) + int'(it.cycles);
    mpos = int'(mode_pos);
    // Frame wrap reloads the line-cycle counter with the remainder.
    while (fpos >= FRAME_TOTAL) begin
      fpos -= FRAME_TOTAL;
      mpos = fpos;
    end
    scan_line = fpos / LINE_CYCLES;

    // Compare only while the LCD is on; the request fires on the rising flag.
    if (it.lcd_enable) begin
      if (scan_line == int'(it.line_compare)) begin
        if (!line_match) begin
          line_match = 1'b1;
          if (it.match_irq_enable) r.stat_request = 1'b1;
        end
      end else begin
        line_match = 1'b0;
      end
    end

    if (fpos >= VBLANK_START) begin
      // Line-cycle counter holds during vblank.
      if (cur_mode != MODE_VBLANK) begin
        cur_mode          = MODE_VBLANK;
        r.present_frame   = 1'b1;
        r.vblank_request  = 1'b1;
        if (it.vblank_stat_enable) r.stat_request = 1'b1;
      end
    end else begin
      mpos = (mpos + int'(it.cycles)) % LINE_CYCLES;
      if (mpos <= MODE2_END) begin
        if (cur_mode != MODE_SCAN) begin
          cur_mode = MODE_SCAN;
          if (it.oam_irq_enable) r.stat_request = 1'b1;
        end
      end else if (mpos <= MODE3_END) begin
        cur_mode = MODE_TRANSFER;
      end else if (cur_mode != MODE_HBLANK) begin
        cur_mode      = MODE_HBLANK;
        r.render_line = 1'b1;
        if (it.hblank_irq_enable) r.stat_request = 1'b1;
      end
    end

    frame_pos     = fpos[16:0];
    mode_pos      = mpos[8:0];
    r.line_number = scan_line[7:0];
    r.lcd_mode    = cur_mode;
    r.coincidence = line_match;
  endtask

  // Random item. Bias the step size toward large jumps so that several whole
  // frames pass, and aim the compare value at the line the step lands on.
  function automatic step_item_t random_step();
    step_item_t it;
    int pick;
    int landing;
    pick = $urandom_range(99);
    if (pick < 55)      it.cycles = 8'($urandom_range(255, 200));
    else if (pick < 85) it.cycles = 8'($urandom_range(255));
    else                it.cycles = 8'($urandom_range(3));
    landing = ((int'(frame_pos) + int'(it.cycles)) % FRAME_TOTAL) / LINE_CYCLES;
    pick = $urandom_range(99);
    if (pick < 40)      it.line_compare = 8'(landing);
    else if (pick < 55) it.line_compare = 8'(frame_pos / LINE_CYCLES);
    else                it.line_compare = 8'($urandom_range(255));
    it.lcd_enable         = ($urandom_range(99) < 85);
    it.hblank_irq_enable  = 1'($urandom_range(1));
    it.vblank_stat_enable = 1'($urandom_range(1));
    it.oam_irq_enable     = 1'($urandom_range(1));
    it.match_irq_enable   = 1'($urandom_range(1));
    return it;
  endfunction

  // Send one item. Called just after a rising edge; returns at the edge that
  // accepts it, with the expected report queued.
  task automatic send_step(input step_item_t it, input logic typed,
                           input report_item_t want);
    report_item_t predicted;
    // Pick the idle mix for this stretch of the run.
    if (items_sent < 340) begin
      send_idle_pct = 31;
      recv_idle_pct = 82;
    end else if (items_sent < 680) begin
      send_idle_pct = 82;
      recv_idle_pct = 31;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      step.valid <= 1'b0;
      @(posedge clk);
    end
    step.valid <= 1'b1;
    step.data  <= it;
    @(posedge clk);
    while (!step.ready) @(posedge clk);
    advance_timing(it, predicted);
    expected_reports.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Report side: check each accepted item, then stall at random.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      report.ready <= 1'b0;
    end else begin
      if (report.valid && report.ready) begin
        got_report = report.data;
        if (expected_reports.size() == 0) begin
          flag_error("report item with nothing expected");
        end else begin
          want_report = expected_reports.pop_front();
          check_field("line_number", int'(got_report.line_number),
                      int'(want_report.line_number));
          check_field("lcd_mode", int'(got_report.lcd_mode),
                      int'(want_report.lcd_mode));
          check_field("coincidence", int'(got_report.coincidence),
                      int'(want_report.coincidence));
          check_field("vblank_request", int'(got_report.vblank_request),
                      int'(want_report.vblank_request));
          check_field("stat_request", int'(got_report.stat_request),
                      int'(want_report.stat_request));
          check_field("render_line", int'(got_report.render_line),
                      int'(want_report.render_line));
          check_field("present_frame", int'(got_report.present_frame),
                      int'(want_report.present_frame));
        end
      end
      report.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run when no handshake happens for too long.
  always @(posedge clk) begin
    if ((step.valid && step.ready) || (report.valid && report.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    step.valid    = 1'b0;
    step.data     = '0;
    frame_pos     = '0;
    mode_pos      = '0;
    cur_mode      = MODE_HBLANK;
    line_match    = 1'b0;
    error_count   = 0;
    items_sent    = 0;
    send_idle_pct = 31;
    recv_idle_pct = 82;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table.
    for (int i = 0; i < PROBE_COUNT; i++)
      send_step(probe_table[i].stim, probe_table[i].typed, probe_table[i].want);

    // Random part; the large steps carry the run through vblank entry and
    // the wrap reload more than once.
    for (int n = 0; n < RANDOM_ITEMS; n++)
      send_step(random_step(), 1'b0, '0);

    step.valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/lmtc_pkg.sv
hw/rtl/lmtc_step_if.sv
hw/rtl/lmtc_report_if.sv
hw/rtl/lmtc_step.sv
hw/rtl/lcd_mode_timing_controller_unit.sv
hw/rtl/lmtc_checker.sv
bench/tb_lcd_mode_timing_controller_unit.sv
